// ----- rtl/random_distinct_index_sampler_top_assert.svh -----
// ----------------------------------------------------------------------------
// Sampler assertion macros
// Immediate-cycle and next-cycle implication checks on clk_i / rst_ni.
// ----------------------------------------------------------------------------
`ifndef RANDOM_DISTINCT_INDEX_SAMPLER_TOP_ASSERT_SVH
`define RANDOM_DISTINCT_INDEX_SAMPLER_TOP_ASSERT_SVH

// check cons in the cycle where ante holds
`define RDIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante holds
`define RDIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rdis_pkg.sv -----
// ----------------------------------------------------------------------------
// Sampler package
// Widths, xorshift step, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package rdis_pkg;

  localparam int unsigned MAX_RANGE_DEF = 64;
  localparam int unsigned TOP_W         = 7;
  localparam int unsigned OUT_W         = 6;
  localparam int unsigned GEN_W         = 32;
  localparam logic [TOP_W-1:0] RESULT_LIMIT = 7'd64;

  localparam int unsigned XS_A = 13;
  localparam int unsigned XS_B = 17;
  localparam int unsigned XS_C = 5;

  localparam int unsigned MOD_BITS  = 8;
  localparam int unsigned MOD_STEPS = GEN_W / MOD_BITS;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

  function automatic logic [GEN_W-1:0] xs_step(input logic [GEN_W-1:0] x);
    logic [GEN_W-1:0] v;
    v = x;
    v = v ^ (v << XS_A);
    v = v ^ (v >> XS_B);
    v = v ^ (v << XS_C);
    return v;
  endfunction

  localparam logic [GEN_W-1:0] XS_INIT = xs_step(32'd1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_GEN,
    ST_MOD,
    ST_WRP,
    ST_WRI,
    ST_ERD,
    ST_EOUT,
    ST_NONE
  } state_e;

  typedef struct packed {
    logic load_req;
    logic clr_idx;
    logic inc_idx;
    logic fill_wr;
    logic gen_step;
    logic swap_rd;
    logic wr_p;
    logic wr_i;
    logic emit_rd;
    logic emit_out;
    logic emit_none;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic idx_last;
    logic n_zero;
    logic mod_busy;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/rdis_if.sv -----
// ----------------------------------------------------------------------------
// Sampler channel interfaces
// Request, result and seed write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rdis_req_if import rdis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TOP_W-1:0] range_top;
  logic [TOP_W-1:0] count;

  modport source (output valid, output range_top, output count, input ready);
  modport sink (input valid, input range_top, input count, output ready);
endinterface

interface rdis_rsp_if import rdis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] index_value;
  logic             last;
  logic             none;

  modport source (output valid, output index_value, output last, output none, input ready);
  modport sink (input valid, input index_value, input last, input none, output ready);
endinterface

interface rdis_cfg_if import rdis_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [GEN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rdis_mod.sv -----
// ----------------------------------------------------------------------------
// Sampler remainder unit
// Restoring remainder of a 32-bit word by the range, eight bits per cycle.
// ----------------------------------------------------------------------------
module rdis_mod import rdis_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [GEN_W-1:0] dividend_i,
  input  logic [TOP_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [TOP_W-1:0] rem_o
);

  localparam logic [MOD_CNT_W-1:0] CNT_LAST = MOD_CNT_W'(MOD_STEPS - 1);

  logic                 busy_q, busy_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [GEN_W-1:0]     dvd_q, dvd_w;
  logic [TOP_W-1:0]     rem_q, rem_w;
  logic [TOP_W-1:0]     div_q;
  logic [TOP_W:0]       part;

  always_comb begin
    rem_w = rem_q;
    dvd_w = dvd_q;
    part  = '0;
    for (int k = 0; k < MOD_BITS; k++) begin
      part  = {rem_w, dvd_w[GEN_W-1]};
      dvd_w = {dvd_w[GEN_W-2:0], 1'b0};
      if (part >= {1'b0, div_q}) begin
        part = part - {1'b0, div_q};
      end
      rem_w = part[TOP_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + MOD_CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_w;
      rem_q <= rem_w;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/rdis_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sampler controller
// Sequences fill, shuffle and emit phases of one request.
// ----------------------------------------------------------------------------
module rdis_ctrl import rdis_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.clr_idx  = 1'b1;
          state_d        = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sts_i.idx_end) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = ST_GEN;
        end else begin
          cmd_o.fill_wr = 1'b1;
          cmd_o.inc_idx = 1'b1;
        end
      end
      ST_GEN: begin
        if (sts_i.idx_end) begin
          cmd_o.clr_idx = 1'b1;
          state_d       = sts_i.n_zero ? ST_NONE : ST_ERD;
        end else begin
          cmd_o.gen_step = 1'b1;
          state_d        = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!sts_i.mod_busy) begin
          cmd_o.swap_rd = 1'b1;
          state_d       = ST_WRP;
        end
      end
      ST_WRP: begin
        cmd_o.wr_p = 1'b1;
        state_d    = ST_WRI;
      end
      ST_WRI: begin
        cmd_o.wr_i    = 1'b1;
        cmd_o.inc_idx = 1'b1;
        state_d       = ST_GEN;
      end
      ST_ERD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EOUT;
      end
      ST_EOUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_out = 1'b1;
          cmd_o.inc_idx  = 1'b1;
          state_d        = sts_i.idx_last ? ST_IDLE : ST_ERD;
        end
      end
      ST_NONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_none = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/rdis_dp.sv -----
// ----------------------------------------------------------------------------
// Sampler datapath
// Generator, shuffle table, position counter and output word register.
// ----------------------------------------------------------------------------
module rdis_dp import rdis_pkg::*; #(
  parameter int unsigned MAX_RANGE = MAX_RANGE_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic [TOP_W-1:0] req_range_top_i,
  input  logic [TOP_W-1:0] req_count_i,
  input  logic             cfg_valid_i,
  input  logic [GEN_W-1:0] cfg_data_i,
  input  logic             rsp_ready_i,
  output logic             rsp_valid_o,
  output logic [OUT_W-1:0] rsp_index_value_o,
  output logic             rsp_last_o,
  output logic             rsp_none_o
);

  localparam int unsigned IDX_W   = $clog2(MAX_RANGE);
  localparam int unsigned TOP_MAX = (1 << TOP_W) - 1;
  localparam int unsigned SAT     = (MAX_RANGE > TOP_MAX) ? TOP_MAX : MAX_RANGE;
  localparam logic [TOP_W-1:0] TOP_SAT = TOP_W'(SAT);

  logic [GEN_W-1:0] gen_q, gen_d;
  logic [GEN_W-1:0] gen_nxt, gen_mag;
  logic [TOP_W-1:0] top_q, n_q, i_q;
  logic [TOP_W-1:0] top_c, cnt_c;
  logic [TOP_W-1:0] rem;
  logic             mod_busy;

  logic [IDX_W+TOP_W-1:0] i_pad, p_pad;
  logic [IDX_W-1:0]       i_idx, p_idx;
  logic [IDX_W-1:0]       tbl_mem [MAX_RANGE];
  logic [IDX_W-1:0]       rd_a_q, rd_b_q;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr, wr_data;
  logic [IDX_W+OUT_W-1:0] ent_pad;

  logic             rsp_valid_q;
  logic [OUT_W-1:0] rsp_index_value_q;
  logic             rsp_last_q, rsp_none_q;
  logic             out_free, idx_last;

  assign gen_nxt = xs_step(gen_q);
  assign gen_mag = gen_nxt[GEN_W-1] ? (~gen_nxt + GEN_W'(1)) : gen_nxt;

  always_comb begin
    gen_d = gen_q;
    if (cfg_valid_i) begin
      gen_d = xs_step(cfg_data_i);
    end else if (cmd_i.gen_step) begin
      gen_d = gen_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= XS_INIT;
    end else begin
      gen_q <= gen_d;
    end
  end

  rdis_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.gen_step),
    .dividend_i (gen_mag),
    .divisor_i  (top_q),
    .busy_o     (mod_busy),
    .rem_o      (rem)
  );

  assign top_c = (req_range_top_i > TOP_SAT) ? TOP_SAT : req_range_top_i;
  assign cnt_c = (req_count_i < top_c) ? req_count_i : top_c;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      top_q <= top_c;
      n_q   <= (cnt_c > RESULT_LIMIT) ? RESULT_LIMIT : cnt_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
    end else if (cmd_i.clr_idx) begin
      i_q <= '0;
    end else if (cmd_i.inc_idx) begin
      i_q <= i_q + TOP_W'(1);
    end
  end

  assign i_pad = {{IDX_W{1'b0}}, i_q};
  assign p_pad = {{IDX_W{1'b0}}, rem};
  assign i_idx = i_pad[IDX_W-1:0];
  assign p_idx = p_pad[IDX_W-1:0];

  always_comb begin
    wr_en   = cmd_i.fill_wr | cmd_i.wr_p | cmd_i.wr_i;
    wr_addr = i_idx;
    wr_data = i_idx;
    if (cmd_i.wr_p) begin
      wr_addr = p_idx;
      wr_data = rd_a_q;
    end else if (cmd_i.wr_i) begin
      wr_data = rd_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.swap_rd || cmd_i.emit_rd) begin
      rd_a_q <= tbl_mem[i_idx];
    end
    if (cmd_i.swap_rd) begin
      rd_b_q <= tbl_mem[p_idx];
    end
  end

  assign ent_pad  = {{OUT_W{1'b0}}, rd_a_q};
  assign out_free = !rsp_valid_q || rsp_ready_i;
  assign idx_last = (i_q + TOP_W'(1)) == n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.emit_out || cmd_i.emit_none) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_out) begin
      rsp_index_value_q <= ent_pad[OUT_W-1:0];
      rsp_last_q        <= idx_last;
      rsp_none_q        <= 1'b0;
    end else if (cmd_i.emit_none) begin
      rsp_index_value_q <= '0;
      rsp_last_q        <= 1'b1;
      rsp_none_q        <= 1'b1;
    end
  end

  assign sts_o.idx_end  = (i_q == top_q);
  assign sts_o.idx_last = idx_last;
  assign sts_o.n_zero   = (n_q == '0);
  assign sts_o.mod_busy = mod_busy;
  assign sts_o.out_free = out_free;

  assign rsp_valid_o       = rsp_valid_q;
  assign rsp_index_value_o = rsp_index_value_q;
  assign rsp_last_o        = rsp_last_q;
  assign rsp_none_o        = rsp_none_q;

endmodule

// ----- rtl/random_distinct_index_sampler_top.sv -----
// ----------------------------------------------------------------------------
// Random distinct index sampler
// A request (range_top, count) fills a table with 0..top-1, where top is
// range_top saturated to MAX_RANGE, swaps each position with one picked by a
// 32-bit xorshift generator reduced modulo top, and returns the first
// min(count, top, 64) entries, the last one flagged; a zero count returns a
// single word flagged none. One request is worked at a time: the table is
// filled one entry at a time, then each swap takes one generator step, a
// remainder (eight quotient bits per cycle) and a read plus two writes on
// the table's single write port, then a table read and an output load per
// result. The user must write the seed through cfg only while the block
// is idle; the block does not enforce it. The seed is taken every cycle.
// ----------------------------------------------------------------------------
module random_distinct_index_sampler_top import rdis_pkg::*; #(
  parameter int unsigned MAX_RANGE = MAX_RANGE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rdis_req_if.sink   req,
  rdis_rsp_if.source rsp,
  rdis_cfg_if.sink   cfg
);

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  rdis_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rdis_dp #(
    .MAX_RANGE (MAX_RANGE)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .req_range_top_i   (req.range_top),
    .req_count_i       (req.count),
    .cfg_valid_i       (cfg.valid),
    .cfg_data_i        (cfg.data),
    .rsp_ready_i       (rsp.ready),
    .rsp_valid_o       (rsp.valid),
    .rsp_index_value_o (rsp.index_value),
    .rsp_last_o        (rsp.last),
    .rsp_none_o        (rsp.none)
  );

endmodule

// ----- rtl/rdis_checker.sv -----
// ----------------------------------------------------------------------------
// Sampler port checker
// Port-level checks on the request and result channels, bound to the top.
// ----------------------------------------------------------------------------
`include "random_distinct_index_sampler_top_assert.svh"

module rdis_checker import rdis_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [OUT_W-1:0] rsp_index_value_i,
  input logic             rsp_last_i,
  input logic             rsp_none_i
);

  `RDIS_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_index_value_i) && $stable(rsp_last_i) && $stable(rsp_none_i), "stalled result word changed")
  `RDIS_ASSERT_NOW(a_none_last, rsp_valid_i && rsp_none_i, rsp_last_i && (rsp_index_value_i == '0), "empty result not last or nonzero")
  `RDIS_ASSERT_NEXT(a_req_busy, req_valid_i && req_ready_i, !req_ready_i, "request taken while busy")

endmodule

bind random_distinct_index_sampler_top rdis_checker u_rdis_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req.valid),
  .req_ready_i       (req.ready),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_index_value_i (rsp.index_value),
  .rsp_last_i        (rsp.last),
  .rsp_none_i        (rsp.none)
);
